// ===== hdl/sexpr_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef SEXPR_TOKENIZER_ASSERT_SVH
`define SEXPR_TOKENIZER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define SX_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SX_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sexpr_pkg.sv =====
// Shared types and constants of the s-expression tokenizer.
// No dependencies; used by the interfaces and every module.
package sexpr_pkg;

	localparam int LINE_BITS_DEF = 16;
	localparam int LINE_OUT_W    = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int MAX_EVENTS    = 3;

	typedef enum logic [2:0] {
		EV_LPAREN = 3'd0,
		EV_RPAREN = 3'd1,
		EV_SCHAR  = 3'd2,
		EV_ACHAR  = 3'd3,
		EV_SEND   = 3'd4,
		EV_AEND   = 3'd5,
		EV_EOT    = 3'd6
	} event_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	// All words caused by one input byte, in emission order.
	typedef struct packed {
		logic [1:0]                   n;
		event_t [MAX_EVENTS-1:0]      ev;
		logic [MAX_EVENTS-1:0][7:0]   ch;
		logic [LINE_OUT_W-1:0]        line;
	} bundle_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ===== hdl/sexpr_ifs.sv =====
// Valid/ready channel interfaces of the tokenizer: text bytes in, token words out.
// Depends on sexpr_pkg.
interface sexpr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, output text_byte, output end_of_text, input ready);
	modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sexpr_out_if;
	logic                                 valid;
	logic                                 ready;
	sexpr_pkg::event_t                    event_res;
	logic [7:0]                           char_out;
	logic [sexpr_pkg::LINE_OUT_W-1:0]     line_number;
	logic                                 last;

	modport source(output valid, output event_res, output char_out, output line_number,
		output last, input ready);
	modport sink(input valid, input event_res, input char_out, input line_number,
		input last, output ready);
endinterface

// ===== hdl/sexpr_front.sv =====
// Lexer front end: takes one byte per cycle while the queue is not full, tracks mode and line count,
// and builds the bundle of up to three words for it. Depends on sexpr_pkg.
`include "sexpr_tokenizer_assert.svh"

module sexpr_front #(
	parameter int LINE_BITS = sexpr_pkg::LINE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	sexpr_in_if.sink          text_in,
	input  logic              full,
	output logic              push,
	output sexpr_pkg::bundle_t bundle
);

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_ATOM = 3'd1,
		M_STR  = 3'd2,
		M_ESC  = 3'd3,
		M_CMT  = 3'd4
	} mode_t;

	typedef struct packed {
		logic              emit;
		sexpr_pkg::event_t ev;
		logic [7:0]        ch;
		mode_t             mode;
		logic              nl;
	} idle_res_t;

	function automatic idle_res_t idle_byte(input logic [7:0] c);
		idle_res_t r;
		r.emit = 1'b0;
		r.ev   = sexpr_pkg::EV_ACHAR;
		r.ch   = '0;
		r.mode = M_IDLE;
		r.nl   = 1'b0;
		if (sexpr_pkg::is_ws(c)) begin
			r.nl = (c == sexpr_pkg::CH_NL);
		end else if (c == sexpr_pkg::CH_SEMI) begin
			r.mode = M_CMT;
		end else if (c == sexpr_pkg::CH_LPAR) begin
			r.emit = 1'b1;
			r.ev   = sexpr_pkg::EV_LPAREN;
		end else if (c == sexpr_pkg::CH_RPAR) begin
			r.emit = 1'b1;
			r.ev   = sexpr_pkg::EV_RPAREN;
		end else if (c == sexpr_pkg::CH_QUOTE) begin
			r.mode = M_STR;
		end else begin
			r.emit = 1'b1;
			r.ev   = sexpr_pkg::EV_ACHAR;
			r.ch   = c;
			r.mode = M_ATOM;
		end
		return r;
	endfunction

	mode_t                          mode_q, mode_d;
	logic [LINE_BITS-1:0]           line_q;
	logic [LINE_BITS+sexpr_pkg::LINE_OUT_W-1:0] line_ext;
	logic                           line_inc, line_rst;
	logic                           accept, stop;
	logic [7:0]                     c;
	logic [1:0]                     k;
	idle_res_t                      id;
	sexpr_pkg::bundle_t             b;

	assign c        = text_in.text_byte;
	assign stop     = text_in.end_of_text || (c == sexpr_pkg::CH_NUL);
	assign line_ext = {{sexpr_pkg::LINE_OUT_W{1'b0}}, line_q};
	assign id       = idle_byte(c);

	always_comb begin
		b        = '0;
		b.line   = line_ext[sexpr_pkg::LINE_OUT_W-1:0];
		k        = 2'd0;
		mode_d   = mode_q;
		line_inc = 1'b0;
		line_rst = 1'b0;
		if (stop) begin
			unique case (mode_q)
				M_ATOM: begin
					b.ev[k] = sexpr_pkg::EV_AEND; k = k + 2'd1;
				end
				M_STR: begin
					b.ev[k] = sexpr_pkg::EV_SEND; k = k + 2'd1;
				end
				M_ESC: begin
					// dangling backslash stays literal
					b.ev[k] = sexpr_pkg::EV_SCHAR; b.ch[k] = sexpr_pkg::CH_BSLASH;
					k = k + 2'd1;
					b.ev[k] = sexpr_pkg::EV_SEND; k = k + 2'd1;
				end
				default: ;
			endcase
			b.ev[k]  = sexpr_pkg::EV_EOT; k = k + 2'd1;
			mode_d   = M_IDLE;
			line_rst = 1'b1;
		end else begin
			unique case (mode_q)
				M_ATOM: begin
					if (sexpr_pkg::is_ws(c) || c == sexpr_pkg::CH_LPAR
						|| c == sexpr_pkg::CH_RPAR || c == sexpr_pkg::CH_QUOTE
						|| c == sexpr_pkg::CH_SEMI) begin
						b.ev[k] = sexpr_pkg::EV_AEND; k = k + 2'd1;
						if (id.emit) begin
							b.ev[k] = id.ev; b.ch[k] = id.ch; k = k + 2'd1;
						end
						mode_d   = id.mode;
						line_inc = id.nl;
					end else begin
						b.ev[k] = sexpr_pkg::EV_ACHAR; b.ch[k] = c; k = k + 2'd1;
					end
				end
				M_STR: begin
					if (c == sexpr_pkg::CH_QUOTE) begin
						b.ev[k] = sexpr_pkg::EV_SEND; k = k + 2'd1;
						mode_d  = M_IDLE;
					end else if (c == sexpr_pkg::CH_BSLASH) begin
						mode_d = M_ESC;
					end else begin
						b.ev[k] = sexpr_pkg::EV_SCHAR; b.ch[k] = c; k = k + 2'd1;
					end
				end
				M_ESC: begin
					if (c == sexpr_pkg::CH_LOW_N) begin
						b.ev[k] = sexpr_pkg::EV_SCHAR; b.ch[k] = sexpr_pkg::CH_NL;
						k = k + 2'd1;
					end else if (c == sexpr_pkg::CH_LOW_T) begin
						b.ev[k] = sexpr_pkg::EV_SCHAR; b.ch[k] = sexpr_pkg::CH_TAB;
						k = k + 2'd1;
					end else if (c == sexpr_pkg::CH_QUOTE || c == sexpr_pkg::CH_BSLASH) begin
						b.ev[k] = sexpr_pkg::EV_SCHAR; b.ch[k] = c; k = k + 2'd1;
					end else begin
						// unknown escape: backslash, then the byte
						b.ev[k] = sexpr_pkg::EV_SCHAR; b.ch[k] = sexpr_pkg::CH_BSLASH;
						k = k + 2'd1;
						b.ev[k] = sexpr_pkg::EV_SCHAR; b.ch[k] = c; k = k + 2'd1;
					end
					mode_d = M_STR;
				end
				M_CMT: begin
					if (c == sexpr_pkg::CH_NL) begin
						line_inc = 1'b1;
						mode_d   = M_IDLE;
					end
				end
				default: begin
					// idle, and the unreachable codes behave as idle
					if (id.emit) begin
						b.ev[k] = id.ev; b.ch[k] = id.ch; k = k + 2'd1;
					end
					mode_d   = id.mode;
					line_inc = id.nl;
				end
			endcase
		end
		b.n = k;
	end

	assign text_in.ready = !full;
	assign accept        = text_in.valid && !full;
	assign push          = accept && (b.n != 2'd0);
	assign bundle        = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			line_q <= LINE_BITS'(1);
		end else if (accept) begin
			mode_q <= mode_d;
			if (line_rst) begin
				line_q <= LINE_BITS'(1);
			end else if (line_inc && line_q != {LINE_BITS{1'b1}}) begin
				line_q <= line_q + LINE_BITS'(1);
			end
		end
	end

	`SX_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> (mode_q == M_IDLE && line_q == LINE_BITS'(1)), "front not idle in reset")
	`SX_ASSERT(a_eot_restarts, clk, arst_n, (accept && stop) |=> (mode_q == M_IDLE && line_q == LINE_BITS'(1)), "end of text did not restart lexer")
	`SX_ASSERT(a_line_nonzero, clk, arst_n, line_q != '0, "line count wrapped to zero")

endmodule

// ===== hdl/sexpr_queue.sv =====
// Small register queue of word bundles between lexer front and word emitter.
// Depends on sexpr_pkg.
`include "sexpr_tokenizer_assert.svh"

module sexpr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sexpr_pkg::bundle_t wdata,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output sexpr_pkg::bundle_t head
);

	localparam int DEPTH = sexpr_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	sexpr_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]      wr_q, rd_q;
	logic [CW-1:0]      count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`SX_ASSERT(a_no_overflow, clk, arst_n, push |-> (!full || pop), "push into full queue")
	`SX_ASSERT(a_no_underflow, clk, arst_n, pop |-> !empty, "pop from empty queue")
	`SX_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "queue count out of range")

endmodule

// ===== hdl/sexpr_back.sv =====
// Word emitter: walks the head bundle of the queue, one word per handshake,
// and flags the last word of each byte. Depends on sexpr_pkg.
`include "sexpr_tokenizer_assert.svh"

module sexpr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  sexpr_pkg::bundle_t head,
	output logic               pop,
	sexpr_out_if.source        tok_out
);

	logic [1:0] idx_q;
	logic       is_last;
	logic       fire;

	assign is_last = (idx_q == head.n - 2'd1);
	assign fire    = tok_out.valid && tok_out.ready;
	assign pop     = fire && is_last;

	assign tok_out.valid       = !empty;
	assign tok_out.event_res   = head.ev[idx_q];
	assign tok_out.char_out    = head.ch[idx_q];
	assign tok_out.line_number = head.line;
	assign tok_out.last        = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	`SX_ASSERT(a_idx_in_bundle, clk, arst_n, tok_out.valid |-> (head.n != 2'd0 && idx_q < head.n), "word index beyond bundle")
	`SX_ASSERT(a_idx_zero_when_empty, clk, arst_n, empty |-> idx_q == 2'd0, "stale word index with empty queue")
	`SX_ASSERT(a_valid_held, clk, arst_n, (tok_out.valid && !tok_out.ready) |=> tok_out.valid, "word dropped while stalled")

endmodule

// ===== hdl/sexpr_tokenizer.sv =====
// S-expression tokenizer, top level. Depends on sexpr_pkg, sexpr_ifs,
// sexpr_front, sexpr_queue and sexpr_back.
//
// Takes one text byte per cycle on text_in while the queue is not full and
// returns token words on tok_out. A byte is classified in the cycle it is
// accepted; its words (zero to three) go into a four-entry bundle queue and
// are registered there, then go out one word per cycle while tok_out is ready.
// Bytes with one word or none then run at one byte per cycle indefinitely; a
// byte with two or three words holds the output longer, and text_in drops
// ready only once the queue is full. line_number is the line count before
// the byte, saturating at 2**LINE_BITS-1 and shown in 16 bits; end of text
// (flag or zero byte) returns it to 1. No clearing pass is needed after reset.
module sexpr_tokenizer #(
	parameter int LINE_BITS = sexpr_pkg::LINE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sexpr_in_if.sink    text_in,
	sexpr_out_if.source tok_out
);

	logic               push, pop, full, empty;
	sexpr_pkg::bundle_t wdata, head;

	sexpr_front #(
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.full    (full),
		.push    (push),
		.bundle  (wdata)
	);

	sexpr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	sexpr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.tok_out (tok_out)
	);

endmodule
